[rtl/core/tsg_pkg.sv]
// shared types, symbol codes, register indexes and cordic constants for the turtle block
`timescale 1ns / 1ps
`default_nettype none
package tsg_pkg;

   // command characters
   localparam logic [7:0] SYM_MOVE  = 8'h46;
   localparam logic [7:0] SYM_LEFT  = 8'h2B;
   localparam logic [7:0] SYM_RIGHT = 8'h2D;
   localparam logic [7:0] SYM_PUSH  = 8'h5B;
   localparam logic [7:0] SYM_POP   = 8'h5D;

   // decoded operations
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_MOVE  = 3'd1;
   localparam logic [2:0] OP_LEFT  = 3'd2;
   localparam logic [2:0] OP_RIGHT = 3'd3;
   localparam logic [2:0] OP_PUSH  = 3'd4;
   localparam logic [2:0] OP_POP   = 3'd5;

   // register indexes
   localparam logic [2:0] REG_START_X       = 3'd0;
   localparam logic [2:0] REG_START_Y       = 3'd1;
   localparam logic [2:0] REG_START_HEADING = 3'd2;
   localparam logic [2:0] REG_STEP_LENGTH   = 3'd3;
   localparam logic [2:0] REG_TURN_STEP     = 3'd4;

   // result status codes
   localparam logic [1:0] STATUS_SEGMENT   = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   // widest angle the block supports
   localparam int MAX_ANGLE_BITS = 24;

   // cordic setup
   localparam int CORDIC_ITERS = 30;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   typedef struct packed {
      logic [2:0] op;
      logic       first;
   } q_entry_type;

   typedef struct packed {
      logic signed [31:0]         start_x;
      logic signed [31:0]         start_y;
      logic [MAX_ANGLE_BITS-1:0]  start_heading;
      logic [23:0]                step_length;
      logic [MAX_ANGLE_BITS-1:0]  turn_step;
   } cfg_type;

   // arctangent of 2^-i as a fraction of a full turn, 2^32 units
   function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
      logic signed [33:0] v;
      case (i)
         5'd0:  v = 34'sh20000000;
         5'd1:  v = 34'sh12E4051E;
         5'd2:  v = 34'sh09FB385B;
         5'd3:  v = 34'sh051111D4;
         5'd4:  v = 34'sh028B0D43;
         5'd5:  v = 34'sh0145D7E1;
         5'd6:  v = 34'sh00A2F61E;
         5'd7:  v = 34'sh00517C55;
         5'd8:  v = 34'sh0028BE53;
         5'd9:  v = 34'sh00145F2F;
         5'd10: v = 34'sh000A2F98;
         5'd11: v = 34'sh000517CC;
         5'd12: v = 34'sh00028BE6;
         5'd13: v = 34'sh000145F3;
         5'd14: v = 34'sh0000A2FA;
         5'd15: v = 34'sh0000517D;
         5'd16: v = 34'sh000028BE;
         5'd17: v = 34'sh0000145F;
         5'd18: v = 34'sh00000A30;
         5'd19: v = 34'sh00000518;
         5'd20: v = 34'sh0000028C;
         5'd21: v = 34'sh00000146;
         5'd22: v = 34'sh000000A3;
         5'd23: v = 34'sh00000051;
         5'd24: v = 34'sh00000029;
         5'd25: v = 34'sh00000014;
         5'd26: v = 34'sh0000000A;
         5'd27: v = 34'sh00000005;
         5'd28: v = 34'sh00000003;
         5'd29: v = 34'sh00000001;
         default: v = 34'sh0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[rtl/core/turtle_segment_generator_top.sv]
// top level of the turtle segment generator: config registers, front end and back end
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_symbol, req_first
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_status, rsp_from_x/y, rsp_to_x/y
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// turns, pushes and ignored symbols are handled in the back end's idle state, a pop also reads the stack ram
// a move runs 30 cordic iterations, then one step multiply, then one round and add
// a two entry queue lets the front end keep taking symbols while the back end is busy
// reset is synchronous; the pose stack needs no clearing, the count starts at zero
// the result register holds a transaction until rsp_ready; the back end waits on it only
// when it has a new result to place there
`timescale 1ns / 1ps
`default_nettype none
module turtle_segment_generator_top #(
   parameter int STACK_DEPTH = 64,
   parameter int ANGLE_BITS  = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_symbol,
   input  wire logic               req_first,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_from_x,
   output logic signed [31:0]      rsp_from_y,
   output logic signed [31:0]      rsp_to_x,
   output logic signed [31:0]      rsp_to_y,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   import tsg_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   q_entry_type q_entry;
   logic        q_valid, q_pop;
   logic [MAX_ANGLE_BITS-1:0] angle_wr;
   logic [MAX_ANGLE_BITS-1:0] angle_masked;

   assign csr_ready = 1'b1;

   // angle registers keep only the low sixteen bits, then the angle width
   always_comb begin
      angle_wr     = {{(MAX_ANGLE_BITS - 16){1'b0}}, csr_data[15:0]};
      angle_masked = '0;
      angle_masked[ANGLE_BITS-1:0] = angle_wr[ANGLE_BITS-1:0];
   end

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_START_X:       cfg_in.start_x       = csr_data;
            REG_START_Y:       cfg_in.start_y       = csr_data;
            REG_START_HEADING: cfg_in.start_heading = angle_masked;
            REG_STEP_LENGTH:   cfg_in.step_length   = csr_data[23:0];
            REG_TURN_STEP:     cfg_in.turn_step     = angle_masked;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_x       <= '0;
         cfg_ff.start_y       <= '0;
         cfg_ff.start_heading <= '0;
         cfg_ff.step_length   <= 24'd65536;
         cfg_ff.turn_step     <= MAX_ANGLE_BITS'(16384);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_symbol (req_symbol),
      .req_first  (req_first),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   tsg_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .ANGLE_BITS  (ANGLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_from_x (rsp_from_x),
      .rsp_from_y (rsp_from_y),
      .rsp_to_x   (rsp_to_x),
      .rsp_to_y   (rsp_to_y)
   );

endmodule
`default_nettype wire

[rtl/core/tsg_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tsg_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[rtl/core/tsg_front.sv]
// front end: takes symbols, decodes them and queues the useful ones for the back end
`timescale 1ns / 1ps
`default_nettype none
module tsg_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_symbol,
   input  wire logic              req_first,
   output logic                   q_valid,
   output tsg_pkg::q_entry_type   q_entry,
   input  wire logic              q_pop
);
   import tsg_pkg::*;

   q_entry_type slot_ff [2];
   q_entry_type dec;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        push;

   // symbol decode
   always_comb begin
      dec.first = req_first;
      case (req_symbol)
         SYM_MOVE:  dec.op = OP_MOVE;
         SYM_LEFT:  dec.op = OP_LEFT;
         SYM_RIGHT: dec.op = OP_RIGHT;
         SYM_PUSH:  dec.op = OP_PUSH;
         SYM_POP:   dec.op = OP_POP;
         default:   dec.op = OP_NONE;
      endcase
   end

   // symbols with no effect are dropped here
   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready && ((dec.op != OP_NONE) || dec.first);
   assign q_valid   = (fill_ff != 2'd0);
   assign q_entry   = slot_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule
`default_nettype wire

[rtl/core/tsg_back.sv]
// back end: pose state, pose stack, cordic, step multiply and result register
`timescale 1ns / 1ps
`default_nettype none
module tsg_back #(
   parameter int STACK_DEPTH = 64,
   parameter int ANGLE_BITS  = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tsg_pkg::cfg_type     cfg,
   input  wire logic                 q_valid,
   input  wire tsg_pkg::q_entry_type q_entry,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_status,
   output logic signed [31:0]        rsp_from_x,
   output logic signed [31:0]        rsp_from_y,
   output logic signed [31:0]        rsp_to_x,
   output logic signed [31:0]        rsp_to_y
);
   import tsg_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int PW = 64 + ANGLE_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CORDIC = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_EMIT   = 3'd3;
   localparam logic [2:0] ST_POP    = 3'd4;

   localparam logic signed [33:0] QUARTER  = 34'sh040000000;
   localparam logic signed [33:0] HALF     = 34'sh080000000;
   localparam logic signed [33:0] SAT_HI   = 34'sh07FFFFFFF;
   localparam logic signed [33:0] SAT_LO   = -34'sd2147483648;
   localparam logic signed [56:0] ROUND    = 57'sh20000000;

   logic [2:0]              state_ff, state_in;
   logic signed [31:0]      pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic [ANGLE_BITS-1:0]   head_ff, head_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [4:0]              iter_ff, iter_in;
   logic signed [33:0]      cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic                    neg_ff, neg_in;
   logic signed [56:0]      px_ff, px_in, py_ff, py_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              status_ff, status_in;
   logic signed [31:0]      fx_ff, fx_in, fy_ff, fy_in, tx_ff, tx_in, ty_ff, ty_in;

   logic signed [31:0]      eff_x, eff_y;
   logic [ANGLE_BITS-1:0]   eff_h;
   logic [CW-1:0]           eff_cnt;
   logic                    is_err, take, slot_free;
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr, ram_raddr;
   logic [PW-1:0]           ram_wdata, ram_rdata;
   logic [CW-1:0]           cnt_dec;
   logic [31:0]             angle;
   logic signed [33:0]      z0, xs, ys;
   logic                    fold;
   logic signed [24:0]      step_s;
   logic signed [31:0]      cos_q, sin_q;
   logic signed [56:0]      rx, ry;
   logic signed [33:0]      sum_x, sum_y;
   logic signed [31:0]      sat_x, sat_y;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // pose seen by the queued op, after an optional reload
   always_comb begin
      eff_x   = q_entry.first ? cfg.start_x : pen_x_ff;
      eff_y   = q_entry.first ? cfg.start_y : pen_y_ff;
      eff_h   = q_entry.first ? cfg.start_heading[ANGLE_BITS-1:0] : head_ff;
      eff_cnt = q_entry.first ? '0 : count_ff;
      is_err  = ((q_entry.op == OP_PUSH) && (eff_cnt == CW'(STACK_DEPTH))) ||
                ((q_entry.op == OP_POP) && (eff_cnt == '0));
      take    = (state_ff == ST_IDLE) && q_valid && (!is_err || slot_free);
      cnt_dec = eff_cnt - CW'(1);
   end

   assign q_pop = take;

   // angle fold into the right half plane, fold sign captured with the start of a move
   always_comb begin
      angle = {eff_h, {(32 - ANGLE_BITS){1'b0}}};
      z0    = {{2{angle[31]}}, angle};
      fold  = 1'b0;
      if (z0 > QUARTER) begin
         z0   = z0 - HALF;
         fold = 1'b1;
      end else if (z0 < -QUARTER) begin
         z0   = z0 + HALF;
         fold = 1'b1;
      end
      neg_in = (take && (q_entry.op == OP_MOVE)) ? fold : neg_ff;
   end

   // cordic micro-rotation
   assign xs = cx_ff >>> iter_ff;
   assign ys = cy_ff >>> iter_ff;

   // step multiply operands
   assign step_s = {1'b0, cfg.step_length};
   assign cos_q  = neg_ff ? 32'(-cx_ff) : cx_ff[31:0];
   assign sin_q  = neg_ff ? 32'(-cy_ff) : cy_ff[31:0];

   // rounding and saturating add
   always_comb begin
      rx    = (px_ff + ROUND) >>> 30;
      ry    = (py_ff + ROUND) >>> 30;
      sum_x = {{2{pen_x_ff[31]}}, pen_x_ff} + rx[33:0];
      sum_y = {{2{pen_y_ff[31]}}, pen_y_ff} + ry[33:0];
      if (sum_x > SAT_HI) begin
         sat_x = SAT_HI[31:0];
      end else if (sum_x < SAT_LO) begin
         sat_x = SAT_LO[31:0];
      end else begin
         sat_x = sum_x[31:0];
      end
      if (sum_y > SAT_HI) begin
         sat_y = SAT_HI[31:0];
      end else if (sum_y < SAT_LO) begin
         sat_y = SAT_LO[31:0];
      end else begin
         sat_y = sum_y[31:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      iter_in      = iter_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      ram_we       = 1'b0;
      ram_waddr    = eff_cnt[AW-1:0];
      ram_wdata    = {eff_x, eff_y, eff_h};
      ram_raddr    = cnt_dec[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               pen_x_in = eff_x;
               pen_y_in = eff_y;
               head_in  = eff_h;
               count_in = eff_cnt;
               case (q_entry.op)
                  OP_LEFT:  head_in = eff_h + cfg.turn_step[ANGLE_BITS-1:0];
                  OP_RIGHT: head_in = eff_h - cfg.turn_step[ANGLE_BITS-1:0];
                  OP_PUSH, OP_POP: begin
                     if (is_err) begin
                        rsp_valid_in = 1'b1;
                        status_in    = (q_entry.op == OP_PUSH) ? STATUS_OVERFLOW
                                                               : STATUS_UNDERFLOW;
                        fx_in        = eff_x;
                        fy_in        = eff_y;
                        tx_in        = eff_x;
                        ty_in        = eff_y;
                     end else if (q_entry.op == OP_PUSH) begin
                        ram_we   = 1'b1;
                        count_in = eff_cnt + CW'(1);
                     end else begin
                        count_in = cnt_dec;
                        state_in = ST_POP;
                     end
                  end
                  OP_MOVE: begin
                     cx_in    = CORDIC_GAIN;
                     cy_in    = '0;
                     cz_in    = z0;
                     iter_in  = '0;
                     state_in = ST_CORDIC;
                  end
                  default: ;
               endcase
            end
         end
         ST_CORDIC: begin
            if (cz_ff >= 0) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - atan_entry(iter_ff);
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + atan_entry(iter_ff);
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(CORDIC_ITERS - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            px_in    = step_s * cos_q;
            py_in    = step_s * sin_q;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_SEGMENT;
               fx_in        = pen_x_ff;
               fy_in        = pen_y_ff;
               tx_in        = sat_x;
               ty_in        = sat_y;
               pen_x_in     = sat_x;
               pen_y_in     = sat_y;
               state_in     = ST_IDLE;
            end
         end
         ST_POP: begin
            pen_x_in = ram_rdata[PW-1 -: 32];
            pen_y_in = ram_rdata[PW-33 -: 32];
            head_in  = ram_rdata[ANGLE_BITS-1:0];
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      iter_ff   <= iter_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      neg_ff    <= neg_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      status_ff <= status_in;
      fx_ff     <= fx_in;
      fy_ff     <= fy_in;
      tx_ff     <= tx_in;
      ty_ff     <= ty_in;
   end

   tsg_ram #(
      .WIDTH (PW),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_from_x = fx_ff;
   assign rsp_from_y = fy_ff;
   assign rsp_to_x   = tx_ff;
   assign rsp_to_y   = ty_ff;

   // stack never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("pose stack count beyond depth");

   // cordic counter stays inside the iteration range
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC) |-> (iter_ff < 5'(CORDIC_ITERS)))
      else $error("cordic iteration out of range");

   // no op leaves the queue while the back end is busy
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> ((state_ff == ST_IDLE) && q_valid))
      else $error("queue popped while busy");

   // a move result carries the pen as its start point
   a_emit_from: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && slot_free) |=>
         (rsp_valid_ff && (status_ff == STATUS_SEGMENT) && (fx_ff == $past(pen_x_ff))))
      else $error("segment start differs from pen");

endmodule
`default_nettype wire

[tb/turtle_segment_generator_top_test.sv]
// self-checking testbench for the turtle segment generator: directed and random commands against a pose predictor
`timescale 1ns / 1ps
`default_nettype none
module turtle_segment_generator_top_test;
   import tsg_pkg::*;

   localparam int DEPTH = 64;
   localparam int QUIET_LIMIT = 20000;

   typedef struct {
      logic [7:0] sym;
      logic       first;
   } command_type;

   typedef struct {
      logic [1:0]         status;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
   } segment_type;

   // arctangent of 2^-i in units of 2^32 per turn
   localparam longint ATAN_TURN [30] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_symbol = 8'h00;
   logic               req_first = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_from_x, rsp_from_y, rsp_to_x, rsp_to_y;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = 3'd0;
   logic [31:0]        csr_data = 32'h0;

   // mirrored registers and pose
   logic signed [31:0] cfg_start_x = 0, cfg_start_y = 0;
   logic [15:0]        cfg_start_heading = 0, cfg_turn = 16384;
   logic [23:0]        cfg_step = 24'd65536;
   logic signed [31:0] pen_x = 0, pen_y = 0;
   logic [15:0]        pen_heading = 0;
   logic signed [31:0] saved_x [DEPTH];
   logic signed [31:0] saved_y [DEPTH];
   logic [15:0]        saved_h [DEPTH];
   int                 saved_count = 0;

   command_type pending_cmds[$];
   segment_type expected_segments[$];
   command_type next_cmd;
   segment_type got_seg, want_seg;
   int       mismatches = 0;
   int       items_in = 0;
   int       hold_left = 0;
   bit       hold_done = 0;
   int       quiet_cycles = 0;
   wire      calm = (items_in >= 1000) && (items_in < 1300);

   turtle_segment_generator_top uut (.*);

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -64'sh80000000) return 32'sh80000000;
      return v[31:0];
   endfunction

   // cordic rotation of the heading into cosine and sine, q1.30
   function automatic void heading_sincos(input logic [15:0] h, output longint c,
                                          output longint s);
      logic [31:0] a;
      longint      z, x, y, xs, ys;
      bit          flip;
      a = {h, 16'h0};
      z = longint'(signed'(a));
      flip = 0;
      x = CORDIC_GAIN;
      y = 0;
      if (z > 64'sh40000000) begin
         z = z - 64'sh80000000;
         flip = 1;
      end else if (z < -64'sh40000000) begin
         z = z + 64'sh80000000;
         flip = 1;
      end
      for (int i = 0; i < 30; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - ATAN_TURN[i];
         end else begin
            x = x + ys; y = y - xs; z = z + ATAN_TURN[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic segment_type make_seg(input logic [1:0] st,
                                            input logic signed [31:0] fx,
                                            input logic signed [31:0] fy,
                                            input logic signed [31:0] tx,
                                            input logic signed [31:0] ty);
      segment_type r;
      r.status = st; r.fx = fx; r.fy = fy; r.tx = tx; r.ty = ty;
      return r;
   endfunction

   // advance the pose by one command and queue the segment it yields
   task automatic interpret(input logic [7:0] sym, input logic first);
      longint             c, s, dx, dy;
      logic signed [31:0] nx, ny;
      if (first) begin
         pen_x = cfg_start_x;
         pen_y = cfg_start_y;
         pen_heading = cfg_start_heading;
         saved_count = 0;
      end
      case (sym)
         SYM_MOVE: begin
            heading_sincos(pen_heading, c, s);
            dx = (longint'({40'b0, cfg_step}) * c + 64'sh20000000) >>> 30;
            dy = (longint'({40'b0, cfg_step}) * s + 64'sh20000000) >>> 30;
            nx = clamp32(longint'(pen_x) + dx);
            ny = clamp32(longint'(pen_y) + dy);
            expected_segments.push_back(make_seg(STATUS_SEGMENT, pen_x, pen_y, nx, ny));
            pen_x = nx;
            pen_y = ny;
         end
         SYM_LEFT:  pen_heading = pen_heading + cfg_turn;
         SYM_RIGHT: pen_heading = pen_heading - cfg_turn;
         SYM_PUSH: begin
            if (saved_count >= DEPTH) begin
               expected_segments.push_back(make_seg(STATUS_OVERFLOW, pen_x, pen_y, pen_x, pen_y));
            end else begin
               saved_x[saved_count] = pen_x;
               saved_y[saved_count] = pen_y;
               saved_h[saved_count] = pen_heading;
               saved_count++;
            end
         end
         SYM_POP: begin
            if (saved_count == 0) begin
               expected_segments.push_back(make_seg(STATUS_UNDERFLOW, pen_x, pen_y, pen_x, pen_y));
            end else begin
               saved_count--;
               pen_x = saved_x[saved_count];
               pen_y = saved_y[saved_count];
               pen_heading = saved_h[saved_count];
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d (item count %0d)", field, got, want, items_in);
      mismatches++;
   endtask

   // driver: feeds pending commands, predicting each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            interpret(req_symbol, req_first);
            items_in <= items_in + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_cmds.size() > 0 && (calm || $urandom_range(0, 99) >= 19)) begin
               next_cmd = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_symbol <= next_cmd.sym;
               req_first <= next_cmd.first;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result transaction, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_seg = make_seg(rsp_status, rsp_from_x, rsp_from_y, rsp_to_x, rsp_to_y);
            if (expected_segments.size() == 0) begin
               report_mismatch("unexpected result, status", got_seg.status, -1);
            end else begin
               want_seg = expected_segments.pop_front();
               if (got_seg.status !== want_seg.status)
                  report_mismatch("status", got_seg.status, want_seg.status);
               if (got_seg.fx !== want_seg.fx) report_mismatch("from_x", got_seg.fx, want_seg.fx);
               if (got_seg.fy !== want_seg.fy) report_mismatch("from_y", got_seg.fy, want_seg.fy);
               if (got_seg.tx !== want_seg.tx) report_mismatch("to_x", got_seg.tx, want_seg.tx);
               if (got_seg.ty !== want_seg.ty) report_mismatch("to_y", got_seg.ty, want_seg.ty);
            end
         end
         if (!hold_done && items_in >= 600) begin
            hold_left = 400;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= 19);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_START_X:       cfg_start_x = data;
         REG_START_Y:       cfg_start_y = data;
         REG_START_HEADING: cfg_start_heading = data[15:0];
         REG_STEP_LENGTH:   cfg_step = data[23:0];
         REG_TURN_STEP:     cfg_turn = data[15:0];
         default: ;
      endcase
   endtask

   task automatic add_cmd(input logic [7:0] sym, input logic first);
      command_type c;
      c.sym = sym;
      c.first = first;
      pending_cmds.push_back(c);
   endtask

   // mostly turtle commands, some noise, now and then a deep push or pop run
   task automatic add_random_cmds(input int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 199);
         if (r == 0) begin
            for (int k = 0; k < 66; k++) add_cmd(SYM_PUSH, 1'b0);
         end else if (r == 1) begin
            for (int k = 0; k < 66; k++) add_cmd(SYM_POP, 1'b0);
         end else if (r < 60) add_cmd(SYM_MOVE, $urandom_range(0, 99) < 4);
         else if (r < 90) add_cmd(SYM_LEFT, $urandom_range(0, 99) < 4);
         else if (r < 120) add_cmd(SYM_RIGHT, $urandom_range(0, 99) < 4);
         else if (r < 145) add_cmd(SYM_PUSH, $urandom_range(0, 99) < 4);
         else if (r < 170) add_cmd(SYM_POP, $urandom_range(0, 99) < 4);
         else add_cmd(8'($urandom_range(0, 255)), $urandom_range(0, 1));
      end
   endtask

   task automatic drain;
      while (pending_cmds.size() > 0 || req_valid || expected_segments.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // stimulus sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: moves, turns, stack edges and ignored symbols at reset settings
      add_cmd(SYM_MOVE, 1'b1);
      add_cmd(SYM_LEFT, 1'b0);
      add_cmd(SYM_MOVE, 1'b0);
      add_cmd(SYM_RIGHT, 1'b0);
      add_cmd(SYM_RIGHT, 1'b0);
      add_cmd(SYM_MOVE, 1'b0);
      add_cmd(SYM_PUSH, 1'b0);
      add_cmd(SYM_MOVE, 1'b0);
      add_cmd(SYM_POP, 1'b0);
      add_cmd(SYM_POP, 1'b0);
      add_cmd(8'h00, 1'b0);
      add_cmd(8'hFF, 1'b1);
      add_cmd(SYM_PUSH, 1'b0);
      add_cmd(SYM_POP, 1'b1);
      add_cmd(SYM_MOVE, 1'b0);
      add_random_cmds(260);
      drain();

      // extremes: saturating start, full step, masked heading and turn
      write_reg(REG_START_X, 32'h7FFF0000);
      write_reg(REG_START_Y, 32'h80000000);
      write_reg(REG_START_HEADING, 32'hFFFFFFFF);
      write_reg(REG_STEP_LENGTH, 32'hFFFFFFFF);
      write_reg(REG_TURN_STEP, 32'hABCD0001);
      write_reg(3'd5, 32'h12345678);
      add_cmd(SYM_MOVE, 1'b1);
      add_cmd(SYM_MOVE, 1'b0);
      add_random_cmds(280);
      drain();

      // all zero settings
      write_reg(REG_START_X, 32'h0);
      write_reg(REG_START_Y, 32'h0);
      write_reg(REG_START_HEADING, 32'h0);
      write_reg(REG_STEP_LENGTH, 32'h0);
      write_reg(REG_TURN_STEP, 32'h0);
      add_cmd(SYM_MOVE, 1'b1);
      add_random_cmds(190);
      drain();

      // random settings, twice
      for (int p = 0; p < 2; p++) begin
         write_reg(REG_START_X, $urandom);
         write_reg(REG_START_Y, $urandom);
         write_reg(REG_START_HEADING, $urandom);
         write_reg(REG_STEP_LENGTH, $urandom);
         write_reg(REG_TURN_STEP, $urandom);
         write_reg(3'd7, $urandom);
         add_random_cmds(205);
         drain();
      end

      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_segments.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
rtl/core/tsg_pkg.sv
rtl/core/tsg_ram.sv
rtl/core/tsg_front.sv
rtl/core/tsg_back.sv
rtl/core/turtle_segment_generator_top.sv
tb/turtle_segment_generator_top_test.sv
